// File: rtl/wfc_pkg.sv
//------------------------------------------------------------------------------
// wfc_pkg
// types and constants shared by the word frequency counter
//------------------------------------------------------------------------------
package wfc_pkg;
    localparam int MAX_ENTRIES = 32;
    localparam int MAX_LETTERS = 32;
    localparam int COUNT_BITS  = 16;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic KIND_WORD    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_LONG = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [1:0] PH_OUT  = 2'd0;
    localparam logic [1:0] PH_RUN1 = 2'd1;
    localparam logic [1:0] PH_APOS = 2'd2;
    localparam logic [1:0] PH_RUN2 = 2'd3;

    localparam logic [7:0] CH_APOS = 8'h27;

    typedef struct packed {
        logic       op;
        logic [7:0] char_byte;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [4:0]  entry_index;
        logic [15:0] occurrences;
        logic        is_new;
        logic [5:0]  distinct_words;
        logic [1:0]  status;
        logic        last;
    } t_out;

    function automatic logic f_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7a) ||
               (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic logic [7:0] f_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    endfunction
endpackage

// File: rtl/wfc_if.sv
//------------------------------------------------------------------------------
// wfc_in_if / wfc_out_if
// valid/ready channels of the word frequency counter
//------------------------------------------------------------------------------
interface wfc_in_if;
    import wfc_pkg::*;
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface wfc_out_if;
    import wfc_pkg::*;
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/word_frequency_counter.sv
//------------------------------------------------------------------------------
// word_frequency_counter
// streaming word splitter with a word table and per-word counts
//------------------------------------------------------------------------------
// A text byte that does not end a word is taken in S_IDLE; a letter that
// follows an apostrophe also passes S_LEN. At a word end the table is searched
// entry by entry. S_LCHK checks the length of each entry; an entry of the same
// length goes on to S_CMP, which compares letters up to and including the first
// mismatch (one byte of the entry text ram per cycle). A match then passes
// S_CNT and S_EMIT. A new word is appended in S_CPY and then goes to S_EMIT.
// S_EMIT and S_SUM wait while the output is stalled.
// The table is cleared by resetting its fill count, with no sweep.
module word_frequency_counter #(
    parameter int P_MAX_ENTRIES = wfc_pkg::MAX_ENTRIES,
    parameter int P_MAX_LETTERS = wfc_pkg::MAX_LETTERS,
    parameter int P_COUNT_BITS  = wfc_pkg::COUNT_BITS
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    wfc_in_if.sink    i_req,
    wfc_out_if.source o_res
);
    import wfc_pkg::*;

    localparam int EW = (P_MAX_ENTRIES > 1) ? $clog2(P_MAX_ENTRIES) : 1;
    localparam int LW = (P_MAX_LETTERS > 1) ? $clog2(P_MAX_LETTERS) : 1;
    localparam int NW = $clog2(P_MAX_ENTRIES + 1);
    localparam int WL = $clog2(P_MAX_LETTERS + 2);
    localparam int TD = P_MAX_ENTRIES * P_MAX_LETTERS;
    localparam int TW = (TD > 1) ? $clog2(TD) : 1;
    localparam logic [P_COUNT_BITS-1:0] CMAX = '1;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_LEN   = 8'b00000010,
        S_LCHK  = 8'b00000100,
        S_CMP   = 8'b00001000,
        S_CNT   = 8'b00010000,
        S_CPY   = 8'b00100000,
        S_EMIT  = 8'b01000000,
        S_SUM   = 8'b10000000
    } t_state;

    t_state r_state;
    logic [1:0]  r_phase;
    logic [WL-1:0] r_wlen;
    logic [NW-1:0] r_dist;
    logic [1:0]  r_err;
    logic [EW-1:0] r_ent;
    logic [LW:0]   r_pos;
    logic          r_is_end;
    logic          r_ovalid;
    t_out          r_odata;
    logic [7:0]    r_char;

    // word buffer ram
    logic          wb_we;
    logic [LW-1:0] wb_waddr, wb_raddr;
    logic [7:0]    wb_wdata, wb_rdata;
    // table text ram
    logic          tt_we;
    logic [TW-1:0] tt_waddr, tt_raddr;
    logic [7:0]    tt_rdata;
    // length and count rams
    logic          el_we, ec_we;
    logic [EW-1:0] el_raddr, e_waddr;
    logic [WL-1:0] el_rdata;
    logic [P_COUNT_BITS-1:0] ec_wdata, ec_rdata;

    wfc_ram #(.WIDTH(8), .DEPTH(P_MAX_LETTERS)) u_wbuf (
        .i_clk, .i_we(wb_we), .i_waddr(wb_waddr), .i_wdata(wb_wdata),
        .i_raddr(wb_raddr), .o_rdata(wb_rdata));
    wfc_ram #(.WIDTH(8), .DEPTH(TD)) u_text (
        .i_clk, .i_we(tt_we), .i_waddr(tt_waddr), .i_wdata(wb_rdata),
        .i_raddr(tt_raddr), .o_rdata(tt_rdata));
    wfc_ram #(.WIDTH(WL), .DEPTH(P_MAX_ENTRIES)) u_len (
        .i_clk, .i_we(el_we), .i_waddr(e_waddr), .i_wdata(r_wlen),
        .i_raddr(el_raddr), .o_rdata(el_rdata));
    wfc_ram #(.WIDTH(P_COUNT_BITS), .DEPTH(P_MAX_ENTRIES)) u_cnt (
        .i_clk, .i_we(ec_we), .i_waddr(e_waddr), .i_wdata(ec_wdata),
        .i_raddr(el_raddr), .o_rdata(ec_rdata));

    logic acc, out_free, byte_alnum, pos_end;
    logic [TW-1:0] ent_base;

    assign out_free = !r_ovalid || o_res.ready;
    assign i_req.ready = (r_state == S_IDLE) && out_free;
    assign acc = i_req.valid && i_req.ready;
    assign o_res.valid = r_ovalid;
    assign o_res.data = r_odata;
    assign byte_alnum = f_alnum(i_req.data.char_byte);
    assign ent_base = TW'(r_ent) * TW'(P_MAX_LETTERS);
    assign pos_end = (WL'(r_pos) == r_wlen);

    // ram ports by state; idle pushes the byte, apostrophe first in apos phase
    always_comb begin
        wb_we = 1'b0;
        wb_waddr = r_wlen[LW-1:0];
        wb_wdata = f_lower(i_req.data.char_byte);
        wb_raddr = r_pos[LW-1:0];
        tt_we = 1'b0;
        tt_waddr = ent_base + TW'(r_pos) - TW'(1);
        tt_raddr = ent_base + TW'(r_pos[LW-1:0]);
        el_raddr = r_ent;
        el_we = 1'b0;
        ec_we = 1'b0;
        e_waddr = r_ent;
        ec_wdata = P_COUNT_BITS'(1);
        case (r_state)
            S_IDLE: begin
                if (acc && i_req.data.op == OP_BYTE && r_err == ST_OK && byte_alnum
                    && WL'(r_wlen) < WL'(P_MAX_LETTERS)) begin
                    wb_we = 1'b1;
                    if (r_phase == PH_OUT) begin
                        wb_waddr = '0;
                    end else if (r_phase == PH_APOS) begin
                        wb_wdata = CH_APOS;
                    end
                end
            end
            S_LEN: begin
                el_raddr = '0;
                if (r_char != 8'h00 && r_wlen < WL'(P_MAX_LETTERS)) begin
                    wb_we = 1'b1;
                    wb_wdata = r_char;
                end
            end
            S_LCHK: begin
                if (el_rdata != r_wlen) begin
                    el_raddr = EW'(r_ent + 1'b1);
                end
            end
            S_CMP: begin
                if (tt_rdata != wb_rdata) begin
                    el_raddr = EW'(r_ent + 1'b1);
                end
            end
            S_CNT: begin
                ec_we = 1'b1;
                ec_wdata = (ec_rdata < CMAX) ? ec_rdata + 1'b1 : ec_rdata;
            end
            S_CPY: begin
                tt_we = (r_pos != '0);
                if (pos_end) begin
                    el_we = 1'b1;
                    ec_we = 1'b1;
                end
            end
            default: ;
        endcase
    end

    logic [WL-1:0] n_wlen;
    always_comb begin
        n_wlen = (r_wlen <= WL'(P_MAX_LETTERS)) ? r_wlen + 1'b1 : r_wlen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_OUT;
            r_wlen <= '0;
            r_dist <= '0;
            r_err <= ST_OK;
            r_ovalid <= 1'b0;
            r_ent <= '0;
            r_pos <= '0;
            r_is_end <= 1'b0;
            r_char <= '0;
        end else begin
            if (r_ovalid && o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_is_end <= i_req.data.op;
                        r_char <= 8'h00;
                        if (i_req.data.op == OP_END) begin
                            if (r_err == ST_OK && r_phase != PH_OUT) begin
                                r_state <= S_LEN;
                            end else begin
                                r_state <= S_SUM;
                            end
                        end else if (r_err == ST_OK) begin
                            if (byte_alnum) begin
                                if (r_phase == PH_APOS) begin
                                    r_wlen <= n_wlen;
                                    r_char <= f_lower(i_req.data.char_byte);
                                    r_phase <= PH_RUN2;
                                    r_state <= S_LEN;
                                    r_pos <= '1;
                                end else begin
                                    r_wlen <= (r_phase == PH_OUT) ? WL'(1) : n_wlen;
                                    if (r_phase == PH_OUT) begin
                                        r_phase <= PH_RUN1;
                                    end
                                end
                            end else if (i_req.data.char_byte == CH_APOS
                                         && r_phase == PH_RUN1) begin
                                r_phase <= PH_APOS;
                            end else if (r_phase != PH_OUT) begin
                                r_state <= S_LEN;
                            end
                        end
                    end
                end
                S_LEN: begin
                    if (r_char != 8'h00) begin
                        // apostrophe written at old length, now the letter
                        r_wlen <= n_wlen;
                        r_char <= 8'h00;
                        r_state <= S_IDLE;
                    end else begin
                        r_phase <= PH_OUT;
                        r_ent <= '0;
                        r_pos <= '0;
                        if (r_wlen > WL'(P_MAX_LETTERS)) begin
                            r_err <= ST_TOO_LONG;
                            r_wlen <= '0;
                            r_state <= r_is_end ? S_SUM : S_IDLE;
                        end else if (r_dist >= NW'(P_MAX_ENTRIES)) begin
                            r_err <= ST_FULL;
                            r_wlen <= '0;
                            r_state <= r_is_end ? S_SUM : S_IDLE;
                        end else if (r_dist == '0) begin
                            r_state <= S_CPY;
                        end else begin
                            r_state <= S_LCHK;
                        end
                    end
                end
                S_LCHK: begin
                    // length of r_ent read; first letter also read
                    if (el_rdata == r_wlen) begin
                        r_pos <= r_pos + 1'b1;
                        r_state <= S_CMP;
                    end else if (NW'(r_ent) + 1'b1 == r_dist) begin
                        r_ent <= EW'(r_dist);
                        r_pos <= '0;
                        r_state <= S_CPY;
                    end else begin
                        r_ent <= r_ent + 1'b1;
                        r_pos <= '0;
                    end
                end
                S_CMP: begin
                    if (tt_rdata != wb_rdata) begin
                        r_pos <= '0;
                        if (NW'(r_ent) + 1'b1 == r_dist) begin
                            r_ent <= EW'(r_dist);
                            r_state <= S_CPY;
                        end else begin
                            r_ent <= r_ent + 1'b1;
                            r_state <= S_LCHK;
                        end
                    end else if (pos_end) begin
                        r_state <= S_CNT;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                S_CNT: begin
                    r_odata.kind <= KIND_WORD;
                    r_odata.entry_index <= 5'(r_ent);
                    r_odata.occurrences <= 16'(ec_wdata);
                    r_odata.is_new <= 1'b0;
                    r_state <= S_EMIT;
                end
                S_CPY: begin
                    if (pos_end) begin
                        r_odata.kind <= KIND_WORD;
                        r_odata.entry_index <= 5'(r_ent);
                        r_odata.occurrences <= 16'd1;
                        r_odata.is_new <= 1'b1;
                        r_dist <= r_dist + 1'b1;
                        r_state <= S_EMIT;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_odata.distinct_words <= '0;
                        r_odata.status <= ST_OK;
                        r_odata.last <= !r_is_end;
                        r_wlen <= '0;
                        r_state <= r_is_end ? S_SUM : S_IDLE;
                    end
                end
                S_SUM: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_odata.kind <= KIND_SUMMARY;
                        r_odata.entry_index <= '0;
                        r_odata.occurrences <= '0;
                        r_odata.is_new <= 1'b0;
                        r_odata.distinct_words <= 6'(r_dist);
                        r_odata.status <= r_err;
                        r_odata.last <= 1'b1;
                        r_dist <= '0;
                        r_err <= ST_OK;
                        r_phase <= PH_OUT;
                        r_wlen <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_dist_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dist <= NW'(P_MAX_ENTRIES)) else $error("table fill beyond depth");
    a_busy_no_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_req.ready) else $error("request taken while busy");
    a_sum_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.data.kind == KIND_SUMMARY) |-> o_res.data.last)
        else $error("summary without last");
    a_err_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM && out_free) |=> (r_err == ST_OK && r_dist == '0))
        else $error("table not cleared after summary");
endmodule

// File: rtl/wfc_ram.sv
//------------------------------------------------------------------------------
// wfc_ram
// single write port ram with registered read
//------------------------------------------------------------------------------
module wfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: tb/wfc_checker.sv
//------------------------------------------------------------------------------
// wfc_checker
// watches both channels of the word frequency counter, predicts each result
// from the accepted requests and compares it field by field
//------------------------------------------------------------------------------
module wfc_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic          i_req_ready,
    input  wfc_pkg::t_in  i_req_data,
    input  logic          i_res_valid,
    input  logic          i_res_ready,
    input  wfc_pkg::t_out i_res_data,
    output int            o_fail_count,
    output int            o_pending,
    output int            o_words_seen,
    output int            o_summaries_seen,
    output int            o_errors_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import wfc_pkg::*;

    logic [1:0]  phase;
    logic [7:0]  buf_text [MAX_LETTERS];
    int          buf_len;
    logic [7:0]  tab_text [MAX_ENTRIES][MAX_LETTERS];
    int          tab_len [MAX_ENTRIES];
    int          tab_cnt [MAX_ENTRIES];
    int          n_words;
    logic [1:0]  err;
    t_out        expected_results [$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_results.size();

    function automatic bit is_alnum_ch(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic void push_letter(logic [7:0] c);
        logic [7:0] lc;
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        if (buf_len < MAX_LETTERS) buf_text[buf_len] = lc;
        if (buf_len <= MAX_LETTERS) buf_len++;
    endfunction

    function automatic void clear_text();
        phase   = PH_OUT;
        buf_len = 0;
        n_words = 0;
        err     = ST_OK;
    endfunction

    function automatic void end_word();
        int  len;
        int  i;
        bit  same;
        t_out r;
        len     = buf_len;
        buf_len = 0;
        phase   = PH_OUT;
        if (err != ST_OK || len == 0) return;
        if (len > MAX_LETTERS) begin
            err = ST_TOO_LONG;
            return;
        end
        if (n_words >= MAX_ENTRIES) begin
            err = ST_FULL;
            return;
        end
        r = '0;
        r.kind = KIND_WORD;
        for (i = 0; i < n_words; i++) begin
            same = (tab_len[i] == len);
            for (int j = 0; j < len && same; j++)
                if (tab_text[i][j] != buf_text[j]) same = 0;
            if (same) begin
                if (tab_cnt[i] < (1 << COUNT_BITS) - 1) tab_cnt[i]++;
                r.entry_index = i[4:0];
                r.occurrences = tab_cnt[i][15:0];
                expected_results.push_back(r);
                return;
            end
        end
        for (int j = 0; j < len; j++) tab_text[i][j] = buf_text[j];
        tab_len[i] = len;
        tab_cnt[i] = 1;
        n_words++;
        r.entry_index = i[4:0];
        r.occurrences = 16'd1;
        r.is_new      = 1'b1;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_request(t_in req);
        int   prior_size;
        t_out s;
        prior_size = expected_results.size();
        if (req.op == OP_END) begin
            if (err == ST_OK && phase != PH_OUT) end_word();
            s = '0;
            s.kind           = KIND_SUMMARY;
            s.distinct_words = n_words[5:0];
            s.status         = err;
            expected_results.push_back(s);
            clear_text();
        end else if (err == ST_OK) begin
            if (is_alnum_ch(req.char_byte)) begin
                if (phase == PH_APOS) begin
                    push_letter(CH_APOS);
                    phase = PH_RUN2;
                end else if (phase == PH_OUT) begin
                    buf_len = 0;
                    phase   = PH_RUN1;
                end
                push_letter(req.char_byte);
            end else if (req.char_byte == CH_APOS && phase == PH_RUN1) begin
                phase = PH_APOS;
            end else if (phase != PH_OUT) begin
                end_word();
            end
        end
        if (expected_results.size() > prior_size)
            expected_results[$].last = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_out e;
        if (!i_rst_n) begin
            clear_text();
            expected_results.delete();
            fails            <= 0;
            o_words_seen     <= 0;
            o_summaries_seen <= 0;
            o_errors_seen    <= 0;
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    if (fails < 10) $display("unexpected result %p", i_res_data);
                    fails <= fails + 1;
                end else begin
                    e = expected_results.pop_front();
                    if (e !== i_res_data) begin
                        if (fails < 10) $display("mismatch: expected %p got %p", e, i_res_data);
                        fails <= fails + 1;
                    end
                    if (e.kind == KIND_WORD) o_words_seen <= o_words_seen + 1;
                    else begin
                        o_summaries_seen <= o_summaries_seen + 1;
                        if (e.status != ST_OK) o_errors_seen <= o_errors_seen + 1;
                    end
                end
            end
            if (i_req_valid && i_req_ready) predict_request(i_req_data);
        end
    end
endmodule

// File: tb/tb_word_frequency_counter.sv
//------------------------------------------------------------------------------
// tb_word_frequency_counter
// drives texts of words, separators, apostrophes, overlong words and table
// overflows into the word frequency counter with random idling on both sides
//------------------------------------------------------------------------------
module tb_word_frequency_counter;
    timeunit 1ns;
    timeprecision 1ps;
    import wfc_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycles = 0;
    int   fail_count, pending, words_seen, summaries_seen, errors_seen;
    bit   calm = 0;
    int   sent = 0;
    string vocab [8];

    wfc_in_if  req_if ();
    wfc_out_if res_if ();

    word_frequency_counter u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_res  (res_if.source)
    );

    wfc_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (req_if.valid),
        .i_req_ready     (req_if.ready),
        .i_req_data      (req_if.data),
        .i_res_valid     (res_if.valid),
        .i_res_ready     (res_if.ready),
        .i_res_data      (res_if.data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_words_seen    (words_seen),
        .o_summaries_seen(summaries_seen),
        .o_errors_seen   (errors_seen)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        req_if.valid = 1'b0;
        req_if.data  = '0;
        res_if.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 20000000) begin
            $display("[word_frequency_counter] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk)
        res_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 9);

    task automatic send_request(logic op, logic [7:0] c);
        while (!calm && $urandom_range(99) < 9) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= '{op: op, char_byte: c};
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_request(OP_BYTE, s[i]);
    endtask

    function automatic logic [7:0] rand_alnum();
        int k;
        k = $urandom_range(61);
        if (k < 10) return 8'("0" + k);
        if (k < 36) return 8'("a" + k - 10);
        return 8'("A" + k - 36);
    endfunction

    task automatic send_word(int len);
        for (int i = 0; i < len; i++) send_request(OP_BYTE, rand_alnum());
    endtask

    initial begin
        vocab = '{"the", "a", "don't", "cat", "Zz9", "it's", "x", "Go0d"};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: case folding, apostrophes, non-ascii separators, long word
        send_text("Ab ab'c ab' 'q Z9");
        send_request(OP_BYTE, 8'hff);
        send_request(OP_BYTE, 8'h80);
        send_request(OP_END, 8'h00);
        send_word(33);
        send_request(OP_END, 8'hff);
        send_text("0\x7f");
        send_request(OP_END, 8'h00);
        // table overflow with a repeat word
        for (int w = 0; w < 33; w++) begin
            send_request(OP_BYTE, 8'("a" + w % 26));
            send_request(OP_BYTE, 8'("0" + w / 26));
            send_request(OP_BYTE, " ");
        end
        send_text("a0 ");
        send_request(OP_END, 8'h00);
        // random texts
        while (sent < 1850) begin
            int mode;
            calm = (sent > 900 && sent < 1200);
            mode = $urandom_range(99);
            if (mode < 55) send_text(vocab[$urandom_range(7)]);
            else if (mode < 75) send_word($urandom_range(1, 6));
            else if (mode < 78) send_word($urandom_range(30, 34));
            else if (mode < 83) send_request(OP_BYTE, CH_APOS);
            else if (mode < 88) send_request(OP_BYTE, 8'($urandom_range(255)));
            else if (mode < 92) begin
                send_word($urandom_range(1, 4));
                send_request(OP_BYTE, CH_APOS);
                send_word($urandom_range(1, 4));
            end else if (mode < 97) send_request(OP_BYTE, " ");
            else send_request(OP_END, 8'($urandom_range(255)));
            if (mode < 75) send_request(OP_BYTE, $urandom_range(1) ? " " : ",");
        end
        send_request(OP_END, 8'h00);
        req_if.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (1200) @(posedge i_clk);
        $display("sent %0d requests; checked %0d word results and %0d summaries (%0d with error)",
                 sent, words_seen, summaries_seen, errors_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("[word_frequency_counter] OK");
        end else begin
            $display("[word_frequency_counter] ERROR");
        end
        $finish;
    end
endmodule

// File: files.f
rtl/wfc_pkg.sv
rtl/wfc_if.sv
rtl/wfc_ram.sv
rtl/word_frequency_counter.sv
tb/wfc_checker.sv
tb/tb_word_frequency_counter.sv
